// ===== src/afd_pkg.sv =====
// Shared types and constants for the APA102 strip frame driver.
// No dependencies; every other file except afd_ram imports this package.
`timescale 1ns / 1ps

package afd_pkg;

  localparam int LED_MAX     = 64;
  localparam int PIX_AW      = $clog2(LED_MAX);
  localparam int CNT_W       = $clog2(LED_MAX + 1);
  localparam int OP_W        = 3;
  localparam int IDX_W       = 8;
  localparam int COLOR_W     = 24;
  localparam int SPI_W       = 8;
  localparam int CFG_W       = 7;
  localparam int START_BYTES = 4;
  localparam int END_SHIFT   = 4;   // one end byte per 16 LEDs, rounded up

  typedef enum logic [OP_W-1:0] {
    OP_SET   = 3'd0,
    OP_GET   = 3'd1,
    OP_CLEAR = 3'd2,
    OP_SHOW  = 3'd3,
    OP_TICK  = 3'd4
  } op_t;

  typedef struct packed {
    logic             show;
    logic             tick;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_count;
  } seq_cmd_t;

  typedef struct packed {
    logic              idle;
    logic [PIX_AW-1:0] pix_addr;
    logic [CNT_W-1:0]  count;
  } seq_st_t;

  typedef struct packed {
    logic [SPI_W-1:0] spi_byte;
    logic             byte_valid;
    logic             last;
    logic             power;
    logic             busy;
  } seq_emit_t;

endpackage

// ===== src/afd_item_if.sv =====
// Input item channel: valid/ready handshake plus operation, index and color.
// Depends on afd_pkg.
`timescale 1ns / 1ps

interface afd_item_if import afd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [IDX_W-1:0]   pixel_index;
  logic [COLOR_W-1:0] color;

  modport source (output valid, operation, pixel_index, color, input ready);
  modport sink   (input valid, operation, pixel_index, color, output ready);
endinterface

// ===== src/afd_res_if.sv =====
// Result channel: valid/ready handshake plus one result item per input item.
// Depends on afd_pkg.
`timescale 1ns / 1ps

interface afd_res_if import afd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] read_color;
  logic [SPI_W-1:0]   spi_byte;
  logic               byte_valid;
  logic               frame_last;
  logic               power_on;
  logic               busy_res;

  modport source (output valid, read_color, spi_byte, byte_valid, frame_last,
                  power_on, busy_res, input ready);
  modport sink   (input valid, read_color, spi_byte, byte_valid, frame_last,
                  power_on, busy_res, output ready);
endinterface

// ===== src/afd_cfg_if.sv =====
// Configuration write channel carrying the LED count register.
// Depends on afd_pkg.
`timescale 1ns / 1ps

interface afd_cfg_if import afd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] led_count;

  modport source (output valid, led_count, input ready);
  modport sink   (input valid, led_count, output ready);
endinterface

// ===== src/afd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module afd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/afd_frame_seq.sv =====
// Frame sequencer: phase, byte and slot counters, dark tracking, power level
// and the LED count register. Depends on afd_pkg.
`timescale 1ns / 1ps

module afd_frame_seq import afd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  seq_cmd_t           cmd,
  input  logic [COLOR_W-1:0] pix_color,
  output seq_st_t            st,
  output seq_emit_t          emit
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_PIX   = 4'b0100,
    PH_END   = 4'b1000
  } phase_t;

  localparam logic [1:0] SLOT_MARK  = 2'd0;
  localparam logic [1:0] SLOT_BLUE  = 2'd1;
  localparam logic [1:0] SLOT_RED   = 2'd2;
  localparam logic [1:0] SLOT_GREEN = 2'd3;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] bc_r, bc_nxt;
  logic [1:0]       slot_r, slot_nxt;
  logic             dark_r, dark_nxt;
  logic             power_r, power_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [CNT_W-1:0] bc_inc;
  logic [CNT_W-1:0] end_sum;
  logic [CNT_W-1:0] end_bytes;
  logic [SPI_W-1:0] comp;
  logic [SPI_W-1:0] byte_out;
  logic             last;
  logic             bval;

  assign bc_inc    = bc_r + CNT_W'(1);
  assign end_sum   = count_r + CNT_W'(15);
  assign end_bytes = end_sum >> END_SHIFT;

  always_comb begin
    case (slot_r)
      SLOT_BLUE:  comp = pix_color[7:0];
      SLOT_RED:   comp = pix_color[23:16];
      SLOT_GREEN: comp = pix_color[15:8];
      default:    comp = '1;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    slot_nxt  = slot_r;
    dark_nxt  = dark_r;
    power_nxt = power_r;
    count_nxt = count_r;
    byte_out  = '0;
    last      = 1'b0;
    bval      = 1'b0;

    if (cmd.show && phase_r == PH_IDLE) begin
      power_nxt = 1'b1;
      phase_nxt = PH_START;
      bc_nxt    = '0;
      slot_nxt  = SLOT_MARK;
      dark_nxt  = 1'b1;
    end else if (cmd.tick && phase_r != PH_IDLE) begin
      bval = 1'b1;
      case (phase_r)
        PH_START: begin
          bc_nxt = bc_inc;
          if (bc_inc >= CNT_W'(START_BYTES)) begin
            phase_nxt = PH_PIX;
            bc_nxt    = '0;
            slot_nxt  = SLOT_MARK;
          end
        end
        PH_PIX: begin
          byte_out = comp;
          if (slot_r != SLOT_MARK && comp != '0) begin
            dark_nxt = 1'b0;
          end
          slot_nxt = slot_r + 2'd1;
          if (slot_r == SLOT_GREEN) begin
            bc_nxt = bc_inc;
            if (bc_inc >= count_r) begin
              phase_nxt = PH_END;
              bc_nxt    = '0;
            end
          end
        end
        PH_END: begin
          byte_out = '1;
          bc_nxt   = bc_inc;
          if (bc_inc >= end_bytes) begin
            last      = 1'b1;
            phase_nxt = PH_IDLE;
            bc_nxt    = '0;
            slot_nxt  = SLOT_MARK;
            if (dark_r) begin
              power_nxt = 1'b0;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // count writes only land between frames; clamp to 1..LED_MAX
    if (cmd.cfg_we && phase_r == PH_IDLE) begin
      if (cmd.cfg_count == '0) begin
        count_nxt = CNT_W'(1);
      end else if (int'(cmd.cfg_count) > LED_MAX) begin
        count_nxt = CNT_W'(LED_MAX);
      end else begin
        count_nxt = CNT_W'(cmd.cfg_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bc_r    <= '0;
      slot_r  <= SLOT_MARK;
      dark_r  <= 1'b1;
      power_r <= 1'b0;
      count_r <= CNT_W'(1);
    end else begin
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      slot_r  <= slot_nxt;
      dark_r  <= dark_nxt;
      power_r <= power_nxt;
      count_r <= count_nxt;
    end
  end

  assign st.idle     = (phase_r == PH_IDLE);
  assign st.pix_addr = bc_r[PIX_AW-1:0];
  assign st.count    = count_r;

  assign emit.spi_byte   = byte_out;
  assign emit.byte_valid = bval;
  assign emit.last       = last;
  assign emit.power      = power_nxt;
  assign emit.busy       = (phase_nxt != PH_IDLE);

`ifndef ASSERT_OFF
  a_slot_pix_only: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_PIX |-> slot_r == SLOT_MARK)
    else $error("slot counter left nonzero outside pixel bytes");

  a_power_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    !power_r |-> phase_r == PH_IDLE)
    else $error("frame running with power off");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    last |=> phase_r == PH_IDLE)
    else $error("frame did not end after last byte");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(1) && count_r <= CNT_W'(LED_MAX))
    else $error("LED count out of range");
`endif

endmodule

// ===== src/apa102_strip_frame_driver.sv =====
// APA102 strip frame driver: pixel RAM, frame sequencer, item and result regs.
// Stage 1 holds the item and RAM read data, then the output register the result.
// Items enter only when stage 1 is empty (RAM read, then update and write back).
// Reset: rst_n synchronous active low; clears control, counters, power, LED
// count (to 1) and the per-pixel valid bits, so the store reads as zero at once.
// Depends on afd_pkg, afd_item_if, afd_res_if, afd_cfg_if, afd_ram, afd_frame_seq.
`timescale 1ns / 1ps

module apa102_strip_frame_driver import afd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  afd_item_if.sink   in_ch,
  afd_res_if.source  out_ch,
  afd_cfg_if.sink    cfg_ch
);

  logic               s1_vld_r, s1_vld_nxt;
  op_t                s1_op_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic [COLOR_W-1:0] s1_color_r;
  logic               vbit_r;
  logic [LED_MAX-1:0] vbits_r, vbits_nxt;

  logic               out_vld_r, out_vld_nxt;
  logic [COLOR_W-1:0] out_color_r;
  logic [SPI_W-1:0]   out_byte_r;
  logic               out_bval_r;
  logic               out_last_r;
  logic               out_power_r;
  logic               out_busy_r;

  logic               accept;
  logic               complete;
  logic [PIX_AW-1:0]  raddr;
  logic [COLOR_W-1:0] ram_rdata;
  logic [COLOR_W-1:0] pix;
  logic               idx_ok;
  logic               set_we;
  logic               clr;
  seq_cmd_t           cmd;
  seq_st_t            st;
  seq_emit_t          emit;

  assign in_ch.ready  = !s1_vld_r;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;
  assign complete     = s1_vld_r && (!out_vld_r || out_ch.ready);

  // ticks read the pixel under the byte counter, gets read the requested slot
  assign raddr = (in_ch.operation == OP_TICK) ? st.pix_addr
                                              : in_ch.pixel_index[PIX_AW-1:0];

  assign pix    = vbit_r ? ram_rdata : '0;
  assign idx_ok = s1_idx_r < {{(IDX_W-CNT_W){1'b0}}, st.count};
  assign set_we = complete && s1_op_r == OP_SET && st.idle && idx_ok;
  assign clr    = complete && s1_op_r == OP_CLEAR && st.idle;

  afd_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (LED_MAX)
  ) u_pix_ram (
    .clk   (clk),
    .we    (set_we),
    .waddr (s1_idx_r[PIX_AW-1:0]),
    .wdata (s1_color_r),
    .re    (accept),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cmd.show      = complete && s1_op_r == OP_SHOW;
    cmd.tick      = complete && s1_op_r == OP_TICK;
    cmd.cfg_we    = cfg_ch.valid;
    cmd.cfg_count = cfg_ch.led_count;
  end

  afd_frame_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .pix_color (pix),
    .st        (st),
    .emit      (emit)
  );

  always_comb begin
    vbits_nxt = vbits_r;
    if (clr) begin
      vbits_nxt = '0;
    end else if (set_we) begin
      vbits_nxt[s1_idx_r[PIX_AW-1:0]] = 1'b1;
    end
  end

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (complete) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (complete) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      vbits_r   <= '0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      vbits_r   <= vbits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= op_t'(in_ch.operation);
      s1_idx_r   <= in_ch.pixel_index;
      s1_color_r <= in_ch.color;
      vbit_r     <= vbits_r[raddr];
    end
    if (complete) begin
      out_color_r <= (s1_op_r == OP_GET && idx_ok) ? pix : '0;
      out_byte_r  <= emit.spi_byte;
      out_bval_r  <= emit.byte_valid;
      out_last_r  <= emit.last;
      out_power_r <= emit.power;
      out_busy_r  <= emit.busy;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.read_color = out_color_r;
  assign out_ch.spi_byte   = out_byte_r;
  assign out_ch.byte_valid = out_bval_r;
  assign out_ch.frame_last = out_last_r;
  assign out_ch.power_on   = out_power_r;
  assign out_ch.busy_res   = out_busy_r;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for apa102_strip_frame_driver: directed table, then random frames.
// Depends on afd_pkg, the afd_item_if/afd_res_if/afd_cfg_if interfaces and the RTL top.
`timescale 1ns / 1ps

module testbench;
  import afd_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int SEG_ITEMS   = 85;
  localparam int DRAIN_TAIL  = 10;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam logic [1:0] SLOT_MARK  = 2'd0;
  localparam logic [1:0] SLOT_BLUE  = 2'd1;
  localparam logic [1:0] SLOT_RED   = 2'd2;

  typedef enum logic [1:0] {
    STAGE_IDLE  = 2'd0,
    STAGE_START = 2'd1,
    STAGE_PIXEL = 2'd2,
    STAGE_END   = 2'd3
  } frame_stage_t;

  typedef struct packed {
    logic [COLOR_W-1:0] read_color;
    logic [SPI_W-1:0]   spi_byte;
    logic               byte_valid;
    logic               frame_last;
    logic               power_on;
    logic               busy_res;
  } strip_res_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] col;
    logic               typed;
    strip_res_t         want;
  } stim_row_t;

  localparam strip_res_t RES_QUIET = '0;
  localparam strip_res_t RES_SHOWN = '{read_color: '0, spi_byte: '0, byte_valid: 1'b0,
                                       frame_last: 1'b0, power_on: 1'b1, busy_res: 1'b1};
  localparam strip_res_t RES_WHITE = '{read_color: 24'hFFFFFF, spi_byte: '0,
                                       byte_valid: 1'b0, frame_last: 1'b0,
                                       power_on: 1'b0, busy_res: 1'b0};

  // LED count is 1 after reset, so one pixel frame: 4 start, 4 pixel, 1 end byte
  localparam int DIR_ROWS = 27;
  localparam stim_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    '{OP_GET,       8'd0,   24'h000000, 1'b1, RES_QUIET},
    '{OP_GET,       8'd255, 24'hFFFFFF, 1'b1, RES_QUIET},
    '{OP_TICK,      8'd0,   24'h000000, 1'b1, RES_QUIET},
    '{OP_UNUSED_LO, 8'd0,   24'hFFFFFF, 1'b1, RES_QUIET},
    '{OP_UNUSED_HI, 8'd255, 24'h000000, 1'b1, RES_QUIET},
    '{OP_SET,       8'd0,   24'hFFFFFF, 1'b1, RES_QUIET},
    '{OP_SET,       8'd1,   24'h123456, 1'b1, RES_QUIET},
    '{OP_GET,       8'd0,   24'h000000, 1'b1, RES_WHITE},
    '{OP_GET,       8'd1,   24'h000000, 1'b1, RES_QUIET},
    '{OP_SET,       8'd0,   24'hA1B2C3, 1'b1, RES_QUIET},
    '{OP_SHOW,      8'd0,   24'h000000, 1'b1, RES_SHOWN},
    '{OP_SET,       8'd0,   24'h000000, 1'b0, RES_QUIET},
    '{OP_CLEAR,     8'd0,   24'h000000, 1'b0, RES_QUIET},
    '{OP_SHOW,      8'd0,   24'h000000, 1'b0, RES_QUIET},
    '{OP_TICK,      8'd0,   24'h000000, 1'b0, RES_QUIET},
    '{OP_TICK,      8'd0,   24'h000000, 1'b0, RES_QUIET},
    '{OP_TICK,      8'd0,   24'h000000, 1'b0, RES_QUIET},
    '{OP_TICK,      8'd0,   24'h000000, 1'b0, RES_QUIET},
    '{OP_GET,       8'd0,   24'h000000, 1'b0, RES_QUIET},
    '{OP_TICK,      8'd0,   24'h000000, 1'b0, RES_QUIET},
    '{OP_TICK,      8'd0,   24'h000000, 1'b0, RES_QUIET},
    '{OP_TICK,      8'd0,   24'h000000, 1'b0, RES_QUIET},
    '{OP_TICK,      8'd0,   24'h000000, 1'b0, RES_QUIET},
    '{OP_TICK,      8'd0,   24'h000000, 1'b0, RES_QUIET},
    '{OP_GET,       8'd0,   24'h000000, 1'b0, RES_QUIET},
    '{OP_CLEAR,     8'd0,   24'h000000, 1'b0, RES_QUIET},
    '{OP_GET,       8'd0,   24'h000000, 1'b0, RES_QUIET}
  };

  localparam int COUNT_PLAN [0:11] = '{0, 3, 17, 16, 127, 2, 5, 1, 33, 64, 7, 9};
  localparam int IDLE_PLAN  [0:3]  = '{0, 50, 0, 19};
  localparam int STALL_PLAN [0:3]  = '{0, 0, 50, 19};

  logic clk;
  logic rst_n;

  afd_item_if in_if ();
  afd_res_if  out_if ();
  afd_cfg_if  cfg_if ();

  apa102_strip_frame_driver dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // shadow of the strip state
  logic [COLOR_W-1:0] strip_mem [LED_MAX];
  frame_stage_t       stage;
  int                 byte_n;
  logic [1:0]         slot;
  logic               dark;
  logic               power;
  int                 led_n;

  strip_res_t expected_results [$];
  int items_sent;
  int err_count;
  int frames_done;
  int cycles;
  int in_idle_pct;
  int out_stall_pct;
  int hold_asks;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic reset_shadow();
    foreach (strip_mem[i]) strip_mem[i] = '0;
    stage  = STAGE_IDLE;
    byte_n = 0;
    slot   = SLOT_MARK;
    dark   = 1'b1;
    power  = 1'b0;
    led_n  = 1;
  endtask

  function automatic strip_res_t predict_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                              logic [COLOR_W-1:0] col);
    strip_res_t         r;
    logic               was_idle;
    logic [COLOR_W-1:0] px;
    r = '0;
    was_idle = (stage == STAGE_IDLE);
    case (op)
      OP_SET: begin
        if (was_idle && idx < led_n) strip_mem[idx] = col;
      end
      OP_GET: begin
        if (idx < led_n) r.read_color = strip_mem[idx];
      end
      OP_CLEAR: begin
        if (was_idle) foreach (strip_mem[i]) strip_mem[i] = '0;
      end
      OP_SHOW: begin
        if (was_idle) begin
          power  = 1'b1;
          stage  = STAGE_START;
          byte_n = 0;
          slot   = SLOT_MARK;
          dark   = 1'b1;
        end
      end
      OP_TICK: begin
        if (!was_idle) begin
          r.byte_valid = 1'b1;
          case (stage)
            STAGE_START: begin
              r.spi_byte = 8'h00;
              byte_n++;
              if (byte_n >= START_BYTES) begin
                stage  = STAGE_PIXEL;
                byte_n = 0;
                slot   = SLOT_MARK;
              end
            end
            STAGE_PIXEL: begin
              px = strip_mem[byte_n];
              // pixel bytes go out as marker, blue, red, green
              case (slot)
                SLOT_MARK: r.spi_byte = 8'hFF;
                SLOT_BLUE: r.spi_byte = px[7:0];
                SLOT_RED:  r.spi_byte = px[23:16];
                default:   r.spi_byte = px[15:8];
              endcase
              if (slot != SLOT_MARK && r.spi_byte != 8'h00) dark = 1'b0;
              slot = slot + 2'd1;
              if (slot == SLOT_MARK) begin
                byte_n++;
                if (byte_n >= led_n) begin
                  stage  = STAGE_END;
                  byte_n = 0;
                end
              end
            end
            default: begin
              r.spi_byte = 8'hFF;
              byte_n++;
              if (byte_n >= ((led_n + 15) >> END_SHIFT)) begin
                r.frame_last = 1'b1;
                stage  = STAGE_IDLE;
                byte_n = 0;
                slot   = SLOT_MARK;
                if (dark) power = 1'b0;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
    r.power_on = power;
    r.busy_res = (stage != STAGE_IDLE);
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    if (err_count < 30)
      $display("MISMATCH result %0d %s: got %h want %h", frames_done, what, got, want);
    err_count++;
  endtask

  // one input transfer; the expectation is recorded at the accepting edge
  task automatic send_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                           logic [COLOR_W-1:0] col, logic typed, strip_res_t want);
    strip_res_t r;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.pixel_index <= idx;
    in_if.color       <= col;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    r = predict_item(op, idx, col);
    expected_results.push_back(typed ? want : r);
    items_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_count(int value);
    logic [CFG_W-1:0] v;
    drain();
    v = CFG_W'(value);
    cfg_if.valid     <= 1'b1;
    cfg_if.led_count <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    if (v < 1) led_n = 1;
    else if (v > LED_MAX) led_n = LED_MAX;
    else led_n = v;
  endtask

  // fill a few slots, show, then tick the whole frame with stray items mixed in
  task automatic play_frame();
    int                 n_sets;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] col;
    if ($urandom_range(0, 3) == 0)
      send_item(OP_CLEAR, IDX_W'($urandom), COLOR_W'($urandom), 1'b0, RES_QUIET);
    n_sets = $urandom_range(0, (led_n < 6) ? led_n : 6);
    for (int k = 0; k < n_sets; k++) begin
      if ($urandom_range(0, 9) == 0) idx = IDX_W'($urandom_range(0, 255));
      else idx = IDX_W'($urandom_range(0, led_n - 1));
      case ($urandom_range(0, 4))
        0:       col = '0;
        1:       col = 24'($urandom_range(1, 255)) << (8 * $urandom_range(0, 2));
        default: col = COLOR_W'($urandom);
      endcase
      send_item(OP_SET, idx, col, 1'b0, RES_QUIET);
    end
    if ($urandom_range(0, 2) == 0)
      send_item(OP_GET, IDX_W'($urandom_range(0, led_n)), COLOR_W'($urandom), 1'b0,
                RES_QUIET);
    send_item(OP_SHOW, IDX_W'($urandom), COLOR_W'($urandom), 1'b0, RES_QUIET);
    while (stage != STAGE_IDLE) begin
      if ($urandom_range(0, 9) == 0)
        send_item(OP_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, led_n)),
                  COLOR_W'($urandom), 1'b0, RES_QUIET);
      else
        send_item(OP_TICK, IDX_W'($urandom), COLOR_W'($urandom), 1'b0, RES_QUIET);
    end
  endtask

  task automatic run_segment(int budget);
    int first;
    first = items_sent;
    while (items_sent - first < budget) begin
      if ($urandom_range(0, 99) < 75) begin
        play_frame();
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(OP_W'($urandom_range(0, 7)), IDX_W'($urandom), COLOR_W'($urandom),
                    1'b0, RES_QUIET);
      end
    end
    while (stage != STAGE_IDLE)
      send_item(OP_TICK, IDX_W'($urandom), COLOR_W'($urandom), 1'b0, RES_QUIET);
  endtask

  // result side: check each transfer, then pick ready for the next edge
  initial begin
    strip_res_t got;
    strip_res_t want;
    int         hold_left;
    int         hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.read_color, out_if.spi_byte, out_if.byte_valid, out_if.frame_last,
                out_if.power_on, out_if.busy_res};
        if (got.frame_last) frames_done++;
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected result", got, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.read_color !== want.read_color)
            flag_mismatch("read_color", got.read_color, want.read_color);
          if (got.spi_byte !== want.spi_byte)
            flag_mismatch("spi_byte", got.spi_byte, want.spi_byte);
          if (got.byte_valid !== want.byte_valid)
            flag_mismatch("byte_valid", got.byte_valid, want.byte_valid);
          if (got.frame_last !== want.frame_last)
            flag_mismatch("frame_last", got.frame_last, want.frame_last);
          if (got.power_on !== want.power_on)
            flag_mismatch("power_on", got.power_on, want.power_on);
          if (got.busy_res !== want.busy_res)
            flag_mismatch("busy_res", got.busy_res, want.busy_res);
        end
      end
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      out_if.ready <= rst_n && hold_left == 0 && $urandom_range(0, 99) >= out_stall_pct;
      if (hold_left > 0) hold_left--;
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 expected_results.size());
        $display("FAIL apa102_strip_frame_driver");
        $finish;
      end
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.operation   <= OP_SET;
    in_if.pixel_index <= '0;
    in_if.color       <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.led_count  <= '0;
    items_sent    = 0;
    err_count     = 0;
    frames_done   = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_asks     = 0;
    reset_shadow();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(DIR_TABLE[i].op, DIR_TABLE[i].idx, DIR_TABLE[i].col, DIR_TABLE[i].typed,
                DIR_TABLE[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct   = IDLE_PLAN[ph];
      out_stall_pct = STALL_PLAN[ph];
      for (int s = 0; s < 3; s++) begin
        write_count(COUNT_PLAN[ph * 3 + s]);
        // long result-side hold while items keep coming, to back the block up
        if (ph == 0 && s == 0) hold_asks++;
        run_segment(SEG_ITEMS);
      end
    end

    drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (expected_results.size() != 0) flag_mismatch("results missing", expected_results.size(), 0);
    $display("Ran %0d items with %0d complete frames over LED counts 1 to %0d,", items_sent,
             frames_done, LED_MAX);
    $display("under free-running, sender-gap, receiver-stall and mixed handshakes.");
    if (err_count == 0) begin
      $display("PASS apa102_strip_frame_driver");
    end else begin
      $display("FAIL apa102_strip_frame_driver");
    end
    $finish;
  end

endmodule
